### sv/md5_message_digest_macros.svh
// ----------------------------------------------------------------------------
// MD5 digest assertion macros
// Concurrent assertion helpers; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 assertion failed");
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 assertion failed");
`else
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 package
// Constants, round tables and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } md5_state_t;

  typedef enum logic [1:0] {
    FILL_MSG,
    FILL_PAD,
    FILL_ZERO,
    FILL_LEN
  } fill_sel_t;

  typedef struct packed {
    logic      wr_en;
    fill_sel_t wr_sel;
    logic      count_inc;
    logic      round_start;
    logic      round_step;
    logic      chain_add;
    logic      msg_clear;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] fill_pos;
    logic       round_done;
  } md5_status_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/md5_message_digest.sv
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-serial MD5: one message byte per input word, digest as one output word.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): msg_byte, byte_valid, last_item. Bytes are
// taken one per cycle while the block is idle; the 64th byte of a block
// starts compression (one MD5 round per cycle in a shared round unit),
// and the next word is accepted only once its rounds are done. A word
// with last_item set starts padding: the 0x80 byte, zeros and the
// little-endian bit length are written into the block buffer one byte per
// cycle, each block followed by a compression; a 0x80 byte at position 56
// or later needs one extra block. The digest then stands on the output
// channel until taken; a stalled receiver holds the block with no further
// input accepted. Once the digest is taken the chaining words and byte
// count return to their initial values. Reset (synchronous, active high)
// does the same at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_message_digest_macros.svh"
module md5_message_digest (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_valid,
  input  wire logic        last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_low,
  output logic [63:0]      digest_high
);
  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_status_t status;

  md5_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .byte_valid, .last_item,
    .out_valid, .out_ready, .status, .cmd
  );

  md5_datapath u_dp (
    .clk, .rst, .cmd, .status, .msg_byte, .digest_low, .digest_high
  );

  `MD5_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  `MD5_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `MD5_ASSERT_NEXT(a_clear_fill, clk, rst, out_valid && out_ready, status.fill_pos == 6'd0)
endmodule
`default_nettype wire

### sv/md5_datapath.sv
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, byte count, chaining words and the one-round-per-cycle unit.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire md5_pkg::md5_cmd_t   cmd,
  output md5_pkg::md5_status_t     status,
  input  wire logic [7:0]          msg_byte,
  output logic [63:0]              digest_low,
  output logic [63:0]              digest_high
);
  import md5_pkg::*;

  logic [31:0] block_store [BLOCK_BYTES / 4];
  logic [63:0] byte_total;
  logic [5:0]  fill_pos;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] a, b, c, d;
  logic [5:0]  round;
  logic        busy;
  logic [7:0]  wr_data;
  logic [5:0]  len_pos;
  logic [63:0] bit_len;
  logic [31:0] f, mw, sum, rot;
  logic [3:0]  g;
  logic [5:0]  rnd_next;

  assign bit_len = {byte_total[60:0], 3'b000};
  assign len_pos = fill_pos;

  always_comb begin
    case (cmd.wr_sel)
      FILL_MSG:  wr_data = msg_byte;
      FILL_PAD:  wr_data = PAD_BYTE;
      FILL_ZERO: wr_data = 8'h00;
      default:   wr_data = bit_len[{len_pos[2:0], 3'b000} +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      block_store[fill_pos[5:2]][{fill_pos[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      byte_total <= '0;
    end else if (cmd.count_inc) begin
      byte_total <= byte_total + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pos <= '0;
    end else if (cmd.msg_clear) begin
      fill_pos <= '0;
    end else if (cmd.wr_en) begin
      fill_pos <= fill_pos + 6'd1;
    end
  end

  always_comb begin
    case (round[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = round[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * round + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(3 * round + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(7 * round); end
    endcase
    mw = block_store[g];
    sum = a + f + md5_k(round) + mw;
    rot = (sum << md5_rot(round)) | (sum >> (6'd32 - {1'b0, md5_rot(round)}));
    rnd_next = round + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
    end else if (cmd.round_start) begin
      busy <= 1'b1;
      round <= '0;
    end else if (cmd.round_step && busy) begin
      round <= rnd_next;
      if (round == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  assign status = {fill_pos, busy && (round == 6'd63)};

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a <= ca; b <= cb; c <= cc; d <= cd;
    end else if (cmd.round_step && busy) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      ca <= IV_A; cb <= IV_B; cc <= IV_C; cd <= IV_D;
    end else if (cmd.chain_add) begin
      ca <= ca + d; cb <= cb + (b + rot); cc <= cc + b; cd <= cd + c;
    end
  end

  assign digest_low  = {cb, ca};
  assign digest_high = {cd, cc};
endmodule
`default_nettype wire

### sv/md5_control.sv
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, compression, padding, length and digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_control (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 byte_valid,
  input  wire logic                 last_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire md5_pkg::md5_status_t status,
  output md5_pkg::md5_cmd_t         cmd
);
  import md5_pkg::*;

  md5_state_t state, state_next;
  logic       closing, closing_next;
  logic       final_blk, final_blk_next;
  logic       spill, spill_next;
  logic       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      closing <= 1'b0;
      final_blk <= 1'b0;
      spill <= 1'b0;
    end else begin
      state <= state_next;
      closing <= closing_next;
      final_blk <= final_blk_next;
      spill <= spill_next;
    end
  end

  always_comb begin
    state_next = state;
    closing_next = closing;
    final_blk_next = final_blk;
    spill_next = spill;
    cmd = '0;
    cmd.wr_sel = FILL_MSG;
    in_ready = 1'b0;
    out_valid = 1'b0;
    take = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        take = in_valid;
        if (take) begin
          closing_next = last_item;
          if (byte_valid) begin
            cmd.wr_en = 1'b1;
            cmd.count_inc = 1'b1;
            if (status.fill_pos == 6'd63) begin
              cmd.round_start = 1'b1;
              final_blk_next = 1'b0;
              state_next = ST_ROUND;
            end else if (last_item) begin
              state_next = ST_PAD;
            end
          end else if (last_item) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_done) begin
          cmd.chain_add = 1'b1;
          if (final_blk) begin
            state_next = ST_OUT;
          end else if (closing) begin
            state_next = ST_PAD;
          end else if (spill) begin
            spill_next = 1'b0;
            state_next = ST_LEN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = FILL_PAD;
        closing_next = 1'b0;
        spill_next = (status.fill_pos >= 6'd56);
        if (status.fill_pos == 6'd63) begin
          cmd.round_start = 1'b1;
          final_blk_next = 1'b0;
          state_next = ST_ROUND;
        end else begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = (status.fill_pos >= 6'd56 && !spill) ? FILL_LEN : FILL_ZERO;
        if (status.fill_pos == 6'd63) begin
          cmd.round_start = 1'b1;
          final_blk_next = !spill;
          state_next = ST_ROUND;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.msg_clear = 1'b1;
          closing_next = 1'b0;
          final_blk_next = 1'b0;
          spill_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### test/md5_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 digest checker
// Watches both channels, keeps its own MD5 state per accepted word and
// compares each digest taken with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_valid,
  input  wire logic        last_item,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [63:0] digest_low,
  input  wire logic [63:0] digest_high,
  output int               fail_count,
  output int               pending
);
  import md5_pkg::*;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [63:0] total;
  digest_t     digest_q [$];

  function automatic logic [31:0] round_const(input int i);
    return 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1.0) < 0.0) ?
           -$sin(i + 1.0) : $sin(i + 1.0)))));
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  task automatic compress_block();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t, s;
    int g, sh;
    int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      sh = shifts[(i / 16) * 4 + i % 4];
      s = a + f + round_const(i) + m[g];
      t = d; d = c; c = b;
      b = b + ((s << sh) | (s >> (32 - sh)));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart();
    chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
    total = '0;
  endtask

  task automatic take_word(input logic [7:0] data, input logic has_byte, input logic ends);
    int pos;
    logic [63:0] bits;
    digest_t dg;
    if (has_byte) begin
      blk[total[5:0]] = data;
      total++;
      if (total[5:0] == 0) compress_block();
    end
    if (ends) begin
      pos = total[5:0];
      blk[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 64; i++) blk[i] = '0;
      end
      bits = total << 3;
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
      compress_block();
      dg.lo = {chain[1], chain[0]};
      dg.hi = {chain[3], chain[2]};
      digest_q.push_back(dg);
      restart();
    end
  endtask

  always @(posedge clk) begin
    digest_t want;
    if (rst) begin
      restart();
      fail_count = 0;
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) take_word(msg_byte, byte_valid, last_item);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest", digest_low, 64'd0);
        end else begin
          want = digest_q.pop_front();
          if (digest_low !== want.lo) report("digest_low", digest_low, want.lo);
          if (digest_high !== want.hi) report("digest_high", digest_high, want.hi);
        end
      end
    end
    pending = digest_q.size();
  end
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 digest testbench
// Drives directed and random messages of assorted lengths through the block
// under varying idle patterns and a long receiver hold-off; the checker
// predicts and compares every digest.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = '0;
  logic        byte_valid = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_low, digest_high;
  int          fail_count, pending;
  int          send_idle = 31, recv_idle = 56;
  bit          hold_off = 1'b0;
  int          cycles = 0;

  md5_message_digest dut (.*);
  md5_digest_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle);

  initial begin
    repeat (400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_word(input logic [7:0] data, input logic has_byte, input logic ends);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    msg_byte <= data;
    byte_valid <= has_byte;
    last_item <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message(input int len, input int fill);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      case (fill)
        0: send_word(8'h00, 1'b1, 1'b0);
        1: send_word(8'hff, 1'b1, 1'b0);
        default: send_word(8'($urandom), 1'b1, 1'b0);
      endcase
    end
    if ($urandom_range(1)) send_word(8'($urandom), 1'b0, 1'b1);
    else send_word(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic random_phase(input int words);
    int n = 0, len;
    while (n < words) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(70);
      send_message(len, 2);
      n += len + 1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b1);
    send_message(3, 0);
    send_message(6, 1);
    send_message(2, 2);
    random_phase(450);
    send_idle = 56; recv_idle = 31;
    random_phase(450);
    send_idle = 0; recv_idle = 0;
    send_message(55, 2);
    send_message(56, 2);
    send_message(63, 2);
    send_message(64, 2);
    random_phase(400);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

### md5_message_digest.f
+incdir+sv
sv/md5_pkg.sv
sv/md5_datapath.sv
sv/md5_control.sv
sv/md5_message_digest.sv
test/md5_digest_checker.sv
test/testbench.sv
